[hw/rtl/rau_pkg.sv]
package rau_pkg;

    typedef enum logic [1:0]
    {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef struct packed
    {
        logic [1:0]         func;
        logic signed [31:0] lhs_num;
        logic [30:0]        lhs_den;
        logic signed [31:0] rhs_num;
        logic [30:0]        rhs_den;
    } in_word_t;

    typedef struct packed
    {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic signed [63:0] whole_part;
        logic [61:0]        frac_num;
        logic               is_negative;
        logic               is_whole;
        logic               is_mixed;
        logic               div_by_zero;
    } out_word_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_RED_N_START,
        ST_RED_N_WAIT,
        ST_RED_D_START,
        ST_RED_D_WAIT,
        ST_MIX_START,
        ST_MIX_WAIT,
        ST_OUT
    } state_t;

    // divider request: dividend and divisor, 64 bits unsigned
    typedef struct packed
    {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed
    {
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } div_rsp_t;

endpackage

[hw/rtl/rau_divider.sv]
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    // restoring division, one quotient bit a cycle
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        shifted = {rem_reg[63:0], quo_reg[63]};
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[64])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            else
            begin
                rem_next = diff;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[63:0];

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |-> busy_reg)
        else $error("divider done while idle");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

[hw/rtl/rau_sequencer.sv]
module rau_sequencer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rau_pkg::in_word_t  in_word,
    output logic               in_stall,
    output logic               out_valid,
    output rau_pkg::out_word_t out_word,
    input  logic               out_stall,
    output rau_pkg::div_req_t  dreq,
    input  rau_pkg::div_rsp_t  drsp
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    in_word_t           op_reg, op_next;
    logic signed [63:0] p0_reg, p0_next;
    logic signed [63:0] p1_reg, p1_next;
    logic signed [63:0] p2_reg, p2_next;
    logic [63:0]        mn_reg, mn_next;
    logic [63:0]        md_reg, md_next;
    logic [63:0]        gx_reg, gx_next;
    logic [63:0]        gy_reg, gy_next;
    logic               neg_reg, neg_next;
    out_word_t          res_reg, res_next;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [63:0] n_c, d_c;
    logic [63:0]        whole_m;

    // one shared signed 32x32 multiplier
    assign prod = 64'(ma) * 64'(mb);

    always_comb
    begin
        ma = op_reg.lhs_num;
        mb = {1'b0, op_reg.rhs_den};
        unique case (state_reg)
            ST_MUL0:
            begin
                ma = op_reg.lhs_num;
                mb = (func_t'(op_reg.func) == FUNC_MUL) ? op_reg.rhs_num
                                                          : {1'b0, op_reg.rhs_den};
            end
            ST_MUL1:
            begin
                ma = {1'b0, op_reg.lhs_den};
                mb = op_reg.rhs_num;
            end
            ST_MUL2:
            begin
                ma = {1'b0, op_reg.lhs_den};
                mb = (func_t'(op_reg.func) == FUNC_DIV) ? op_reg.rhs_num
                                                          : {1'b0, op_reg.rhs_den};
            end
            default:
            begin
                ma = op_reg.lhs_num;
                mb = {1'b0, op_reg.rhs_den};
            end
        endcase
    end

    always_comb
    begin
        unique case (func_t'(op_reg.func))
            FUNC_ADD: n_c = p0_reg + p1_reg;
            FUNC_SUB: n_c = p0_reg - p1_reg;
            FUNC_MUL: n_c = p0_reg;
            FUNC_DIV: n_c = p0_reg;
            default:  n_c = p0_reg;
        endcase
        d_c = p2_reg;
    end

    assign whole_m = drsp.quotient;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (in_valid) state_next = ST_MUL0;
            ST_MUL0:        state_next = ST_MUL1;
            ST_MUL1:        state_next = ST_MUL2;
            ST_MUL2:        state_next = ST_COMB;
            ST_COMB:
            begin
                if ((func_t'(op_reg.func) == FUNC_DIV && op_reg.rhs_num == '0)
                    || n_c == '0 || d_c == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_GCD_START;
            end
            ST_GCD_START:   state_next = (gy_reg == '0) ? ST_RED_N_START : ST_GCD_WAIT;
            ST_GCD_WAIT:    if (drsp.done) state_next = ST_GCD_START;
            ST_RED_N_START: state_next = ST_RED_N_WAIT;
            ST_RED_N_WAIT:  if (drsp.done) state_next = ST_RED_D_START;
            ST_RED_D_START: state_next = ST_RED_D_WAIT;
            ST_RED_D_WAIT:  if (drsp.done) state_next = ST_MIX_START;
            ST_MIX_START:   state_next = ST_MIX_WAIT;
            ST_MIX_WAIT:    if (drsp.done) state_next = ST_OUT;
            ST_OUT:         if (!out_stall) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next  = op_reg;
        p0_next  = p0_reg;
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        mn_next  = mn_reg;
        md_next  = md_reg;
        gx_next  = gx_reg;
        gy_next  = gy_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        dreq     = '0;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) op_next = in_word;
            ST_MUL0:  p0_next = prod;
            ST_MUL1:  p1_next = prod;
            ST_MUL2:  p2_next = prod;
            ST_COMB:
            begin
                res_next = '0;
                mn_next  = n_c[63] ? 64'(-n_c) : 64'(n_c);
                md_next  = d_c[63] ? 64'(-d_c) : 64'(d_c);
                neg_next = n_c[63] ^ d_c[63];
                gx_next  = n_c[63] ? 64'(-n_c) : 64'(n_c);
                gy_next  = d_c[63] ? 64'(-d_c) : 64'(d_c);
                if (func_t'(op_reg.func) == FUNC_DIV && op_reg.rhs_num == '0)
                    res_next.div_by_zero = 1'b1;
                else if (n_c == '0)
                begin
                    res_next.res_den  = 63'd1;
                    res_next.is_whole = 1'b1;
                end
                else if (d_c == '0)
                    res_next.div_by_zero = 1'b1;
            end
            ST_GCD_START:
            begin
                if (gy_reg != '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = gx_reg;
                    dreq.divisor  = gy_reg;
                end
            end
            ST_GCD_WAIT:
            begin
                if (drsp.done)
                begin
                    gx_next = gy_reg;
                    gy_next = drsp.remainder;
                end
            end
            ST_RED_N_START:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = mn_reg;
                dreq.divisor  = gx_reg;
            end
            ST_RED_N_WAIT:  if (drsp.done) mn_next = drsp.quotient;
            ST_RED_D_START:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = md_reg;
                dreq.divisor  = gx_reg;
            end
            ST_RED_D_WAIT:  if (drsp.done) md_next = drsp.quotient;
            ST_MIX_START:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = mn_reg;
                dreq.divisor  = md_reg;
            end
            ST_MIX_WAIT:
            begin
                if (drsp.done)
                begin
                    res_next.res_num     = neg_reg ? 64'(-mn_reg) : mn_reg;
                    res_next.res_den     = md_reg[62:0];
                    res_next.whole_part  = neg_reg ? 64'(-whole_m) : whole_m;
                    res_next.frac_num    = drsp.remainder[61:0];
                    res_next.is_negative = neg_reg;
                    res_next.is_whole    = (md_reg == 64'd1);
                    res_next.is_mixed    = (md_reg != 64'd1) && (mn_reg > md_reg);
                    res_next.div_by_zero = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        mn_reg  <= mn_next;
        md_reg  <= md_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_word  = res_reg;

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed under stall");
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_MUL0)
        else $error("accept did not start work");
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RED_N_START |-> gx_reg != '0)
        else $error("zero gcd");

endmodule

[hw/rtl/rational_arithmetic_unit_top.sv]
// rational arithmetic unit: add, subtract, multiply or divide two fractions,
// reduce by the gcd and give the mixed-number form
// input channel: in_valid / in_stall with one in_word_t word; the word is taken
// at an edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with one out_word_t word per input word
// the unit works on one word at a time; in_stall stays high from acceptance
// until the result word has been taken
// the shared 32x32 multiplier forms three products in ST_MUL0, ST_MUL1 and ST_MUL2;
// then a 64-step restoring divider runs the euclid loop, one division per step (up
// to about 90 steps for 64-bit values), the two reductions and the whole-part
// division; zero and divide-by-zero cases go from ST_COMB straight to ST_OUT
// the next word is taken only once the sequencer is back in ST_IDLE, after the
// result word has been taken
// when the receiver stalls, out_valid and the word hold until taken
// reset clears the sequencer to idle; no word is in flight afterwards
module rational_arithmetic_unit_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rau_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output rau_pkg::out_word_t out_word
);
    import rau_pkg::*;

    div_req_t dreq;
    div_rsp_t drsp;

    rau_sequencer u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_word  (out_word),
        .out_stall (out_stall),
        .dreq      (dreq),
        .drsp      (drsp)
    );

    rau_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import rau_pkg::*;

    class fraction_scoreboard;
        out_word_t expected_q[$];
        int        fails;

        function new();
            fails = 0;
        endfunction

        // fraction result in lowest terms plus mixed-number form
        function out_word_t reduce_fraction(in_word_t w);
            out_word_t r;
            longint an, ad, bn, bd, n, d;
            longint unsigned mn, md, x, y, t, g, whole;
            bit neg;
            r  = '0;
            an = $signed(w.lhs_num);
            bn = $signed(w.rhs_num);
            ad = {33'b0, w.lhs_den};
            bd = {33'b0, w.rhs_den};
            case (func_t'(w.func))
                FUNC_ADD:
                begin
                    n = an * bd + ad * bn;
                    d = ad * bd;
                end
                FUNC_SUB:
                begin
                    n = an * bd - ad * bn;
                    d = ad * bd;
                end
                FUNC_MUL:
                begin
                    n = an * bn;
                    d = ad * bd;
                end
                default:
                begin
                    if (bn == 0)
                    begin
                        r.div_by_zero = 1'b1;
                        return r;
                    end
                    n = an * bd;
                    d = ad * bn;
                end
            endcase
            mn = (n < 0) ? -n : n;
            md = (d < 0) ? -d : d;
            if (mn == 0)
            begin
                r.res_den  = 63'd1;
                r.is_whole = 1'b1;
                return r;
            end
            if (md == 0)
            begin
                r.div_by_zero = 1'b1;
                return r;
            end
            neg = (n < 0) != (d < 0);
            x = mn;
            y = md;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            g  = x;
            mn = mn / g;
            md = md / g;
            whole = mn / md;
            r.res_num     = neg ? -mn : mn;
            r.res_den     = md[62:0];
            r.whole_part  = neg ? -whole : whole;
            r.frac_num    = 62'(mn % md);
            r.is_negative = neg;
            r.is_whole    = (md == 1);
            r.is_mixed    = (md != 1) && (mn > md);
            return r;
        endfunction

        function void note_input(in_word_t w);
            expected_q.push_back(reduce_fraction(w));
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                fails++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.res_num !== exp_w.res_num)
            begin
                $display("%0t: res_num exp %0d got %0d", $time, exp_w.res_num, got.res_num);
                fails++;
            end
            if (got.res_den !== exp_w.res_den)
            begin
                $display("%0t: res_den exp %0d got %0d", $time, exp_w.res_den, got.res_den);
                fails++;
            end
            if (got.whole_part !== exp_w.whole_part)
            begin
                $display("%0t: whole_part exp %0d got %0d", $time, exp_w.whole_part,
                         got.whole_part);
                fails++;
            end
            if (got.frac_num !== exp_w.frac_num)
            begin
                $display("%0t: frac_num exp %0d got %0d", $time, exp_w.frac_num, got.frac_num);
                fails++;
            end
            if (got.is_negative !== exp_w.is_negative)
            begin
                $display("%0t: is_negative exp %b got %b", $time, exp_w.is_negative,
                         got.is_negative);
                fails++;
            end
            if (got.is_whole !== exp_w.is_whole)
            begin
                $display("%0t: is_whole exp %b got %b", $time, exp_w.is_whole, got.is_whole);
                fails++;
            end
            if (got.is_mixed !== exp_w.is_mixed)
            begin
                $display("%0t: is_mixed exp %b got %b", $time, exp_w.is_mixed, got.is_mixed);
                fails++;
            end
            if (got.div_by_zero !== exp_w.div_by_zero)
            begin
                $display("%0t: div_by_zero exp %b got %b", $time, exp_w.div_by_zero,
                         got.div_by_zero);
                fails++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    fraction_scoreboard sb;
    bit no_idle;
    int stall_left;

    rational_arithmetic_unit_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // random value with a random number of significant bits
    function logic [31:0] rand_bits(int maxw);
        int wd;
        wd = $urandom_range(1, maxw);
        return 32'($urandom() & ((64'd1 << wd) - 64'd1));
    endfunction

    function in_word_t rand_word();
        in_word_t w;
        w.func    = 2'($urandom_range(0, 3));
        w.lhs_num = ($urandom_range(0, 1)) ? -$signed(rand_bits(31)) : rand_bits(32);
        w.rhs_num = ($urandom_range(0, 1)) ? -$signed(rand_bits(31)) : rand_bits(32);
        w.lhs_den = 31'(rand_bits(31));
        w.rhs_den = 31'(rand_bits(31));
        if (w.lhs_den == 0)
            w.lhs_den = 31'd1;
        if (w.rhs_den == 0)
            w.rhs_den = 31'd1;
        case ($urandom_range(0, 19))
            0: w.rhs_num = 0;
            1: w.lhs_num = 0;
            2:
            begin
                w.rhs_num = w.lhs_num;
                w.rhs_den = w.lhs_den;
            end
            3: w.rhs_den = w.lhs_den;
            default: ;
        endcase
        return w;
    endfunction

    task send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(w);
    endtask

    task send_fraction(func_t f, logic signed [31:0] a_n, logic [30:0] a_d,
                       logic signed [31:0] b_n, logic [30:0] b_d);
        in_word_t w;
        w.func    = f;
        w.lhs_num = a_n;
        w.lhs_den = a_d;
        w.rhs_num = b_n;
        w.rhs_den = b_d;
        send_word(w);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stall, mostly short bursts, a few long ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_word);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
            begin
                case ($urandom_range(0, 99))
                    0, 1:    stall_left <= $urandom_range(20, 120);
                    default: ;
                endcase
                out_stall <= ($urandom_range(0, 99) < 30);
            end
        end
    end

    initial
    begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int  guard;
        func_t f;
        sb       = new();
        no_idle  = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, every operation, zero and divide-by-zero cases
        for (int i = 0; i < 4; i++)
        begin
            f = func_t'(i);
            send_fraction(f, 32'sh8000_0000, 31'd1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
            send_fraction(f, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 31'd1);
            send_fraction(f, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
            send_fraction(f, -32'sd7, 31'd3, 32'sd5, 31'd6);
        end
        send_fraction(FUNC_DIV, 32'sd5, 31'd3, 32'sd0, 31'd9);
        send_fraction(FUNC_MUL, 32'sd0, 31'd0, 32'sd4, 31'd3);
        send_fraction(FUNC_ADD, 32'sd3, 31'd0, 32'sd1, 31'd2);
        send_fraction(FUNC_SUB, 32'sd2, 31'd4, 32'sd1, 31'd2);
        send_fraction(FUNC_ADD, 32'sd9, 31'd3, 32'sd0, 31'd1);
        send_fraction(FUNC_DIV, 32'sd0, 31'd1, -32'sd3, 31'd1);
        send_fraction(FUNC_MUL, -32'sd1, 31'd2, -32'sd1, 31'd2);
        send_fraction(FUNC_DIV, 32'sd4, 31'd0, 32'sd1, 31'd0);

        // hold off until the unit has drained
        wait_drained();

        for (int i = 0; i < 1030; i++)
        begin
            if (i % 200 == 100)
                no_idle = ~no_idle;
            if (i == 500)
                wait_drained();
            send_word(rand_word());
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 2000000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (sb.fails == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
